@@ hdl/ppp_pkg.sv @@
// Shared types and constants of the perspective point projector.
`timescale 1ns / 1ps
`default_nettype none
package ppp_pkg;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    // Dot product width: three shifted products plus an offset, with headroom.
    localparam int DOT_W      = PROD_W - FRAC_BITS + 2;
    localparam int QUO_W      = 32;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;
    localparam int DIV_LAT    = DIV_STAGES + 1;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 64;
    localparam int NUM_ROWS   = 4;
    localparam int NUM_COLS   = 3;
    localparam logic [QUO_W-1:0] CLIP_VAL = QUO_W'(42) << FRAC_BITS;
    localparam logic [QUO_W-1:0] POS_LIMIT = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] NEG_LIMIT = {1'b1, {(QUO_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
        logic                      clipped;
    } t_out;

    typedef struct packed {
        logic valid;
        logic clip;
        logic neg_x;
        logic neg_y;
    } t_side;
endpackage
`default_nettype wire

@@ hdl/ppp_div.sv @@
// Pipelined unsigned fixed-point divider, two quotient bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module ppp_div (
    input  wire logic                         i_clk,
    input  wire logic [ppp_pkg::DOT_W-1:0]    i_num,
    input  wire logic [ppp_pkg::DOT_W-1:0]    i_den,
    output logic      [ppp_pkg::QUO_W-1:0]    o_quo,
    output logic                              o_ovf
);
    import ppp_pkg::*;

    logic [DOT_W:0]   r_rem [DIV_STAGES+1];
    logic [DOT_W-1:0] r_den [DIV_STAGES+1];
    logic [QUO_W-1:0] r_low [DIV_STAGES+1];
    logic [QUO_W-1:0] r_quo [DIV_STAGES+1];
    logic             r_ovf [DIV_STAGES+1];

    logic [DOT_W-1:0] n_top;
    assign n_top = i_num >> (QUO_W - FRAC_BITS);

    // Quotient overflows 32 bits exactly when the leading part reaches the divisor.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= {1'b0, n_top};
        r_den[0] <= i_den;
        r_low[0] <= QUO_W'(i_num) << FRAC_BITS;
        r_quo[0] <= '0;
        r_ovf[0] <= (n_top >= i_den);
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DOT_W:0]     n_rem;
        logic [DIV_STEPS-1:0] n_bits;
        always_comb begin
            logic [DOT_W:0] t;
            n_rem = r_rem[k];
            for (int s = 0; s < DIV_STEPS; s++) begin
                t = {n_rem[DOT_W-1:0], r_low[k][QUO_W-1-s]};
                if (t >= {1'b0, r_den[k]}) begin
                    n_rem = t - {1'b0, r_den[k]};
                    n_bits[DIV_STEPS-1-s] = 1'b1;
                end else begin
                    n_rem = t;
                    n_bits[DIV_STEPS-1-s] = 1'b0;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_rem;
            r_den[k+1] <= r_den[k];
            r_low[k+1] <= r_low[k] << DIV_STEPS;
            r_quo[k+1] <= {r_quo[k][QUO_W-1-DIV_STEPS:0], n_bits};
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    assign o_quo = r_quo[DIV_STAGES];
    assign o_ovf = r_ovf[DIV_STAGES];
endmodule
`default_nettype wire

@@ hdl/perspective_point_projector_unit.sv @@
// Top level of the perspective point projector: 4x4 projection with depth clip.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Requests: drive i_point and pulse i_start; a request is taken at every edge
//   where i_start is high, since o_busy stays low. One request per clock is fine.
//   Results: o_valid is high for exactly one cycle with o_result; the receiver
//   must take it then, it cannot stall the pipe.
//   Pipeline: a request passes through the multiply, sum and magnitude registers,
//   17 divider stages and the saturate/output register.
//   Throughput: one point per clock, set by the fully pipelined multipliers and
//   the two-bit-per-stage restoring dividers (one for x, one for y).
//   Configuration: i_cfg_we writes i_cfg_data into matrix register i_cfg_idx
//   (row0_coef01 .. row3_coef23). Write only while no request is in flight;
//   products sample coefficients on entry, the offset column in the next cycle.
//   Clipped points (|depth| >= |w|, w == 0 included) return 42.0 on both axes
//   with clipped set; others return row/w truncated toward zero, saturated.
//   Reset (i_rst_n low, synchronous) clears the matrix and all valid bits;
//   any request in flight is dropped.
module perspective_point_projector_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire ppp_pkg::t_in                  i_point,
    output logic                               o_valid,
    output ppp_pkg::t_out                      o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [ppp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ppp_pkg::CFG_W-1:0]     i_cfg_data
);
    import ppp_pkg::*;

    // Matrix registers, two Q coefficients each.
    logic [CFG_W-1:0] r_cfg [NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_cfg[i] <= '0;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Never hold off a request: every stage advances each clock.
    assign o_busy = 1'b0;

    logic n_accept;
    assign n_accept = i_start && !o_busy;

    // Coefficient c of row r.
    function automatic logic signed [COORD_W-1:0] coef(input logic [CFG_W-1:0] lo,
                                                      input logic [CFG_W-1:0] hi,
                                                      input int c);
        logic [CFG_W-1:0] w;
        w = (c < 2) ? lo : hi;
        return (c % 2 == 0) ? w[COORD_W-1:0] : w[CFG_W-1:COORD_W];
    endfunction

    // Stage 1: the twelve products.
    logic                      r_v1;
    logic signed [PROD_W-1:0]  r_prod [NUM_ROWS][NUM_COLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= n_accept;
    end

    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_mul
        always_ff @(posedge i_clk) begin
            r_prod[r][0] <= PROD_W'(i_point.point_x) *
                            PROD_W'(coef(r_cfg[2*r], r_cfg[2*r+1], 0));
            r_prod[r][1] <= PROD_W'(i_point.point_y) *
                            PROD_W'(coef(r_cfg[2*r], r_cfg[2*r+1], 1));
            r_prod[r][2] <= PROD_W'(i_point.point_z) *
                            PROD_W'(coef(r_cfg[2*r], r_cfg[2*r+1], 2));
        end
    end

    // Stage 2: floor-shift each product and sum with the offset column.
    logic                     r_v2;
    logic signed [DOT_W-1:0]  r_dot [NUM_ROWS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
    end

    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_sum
        logic signed [COORD_W-1:0] n_c3;
        assign n_c3 = coef(r_cfg[2*r], r_cfg[2*r+1], 3);
        always_ff @(posedge i_clk) begin
            r_dot[r] <= DOT_W'(r_prod[r][0] >>> FRAC_BITS)
                      + DOT_W'(r_prod[r][1] >>> FRAC_BITS)
                      + DOT_W'(r_prod[r][2] >>> FRAC_BITS)
                      + DOT_W'(n_c3);
        end
    end

    // Stage 3: magnitudes and signs.
    logic             r_v3;
    logic [DOT_W-1:0] r_mag [NUM_ROWS];
    logic             r_sgn [NUM_ROWS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
    end

    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_mag
        always_ff @(posedge i_clk) begin
            r_mag[r] <= r_dot[r][DOT_W-1] ? DOT_W'(-r_dot[r]) : DOT_W'(r_dot[r]);
            r_sgn[r] <= r_dot[r][DOT_W-1];
        end
    end

    // Dividers: row 0 and row 1 over w.
    logic [QUO_W-1:0] n_qx, n_qy;
    logic             n_ox, n_oy;

    ppp_div u_div_x (
        .i_clk (i_clk),
        .i_num (r_mag[0]),
        .i_den (r_mag[3]),
        .o_quo (n_qx),
        .o_ovf (n_ox)
    );

    ppp_div u_div_y (
        .i_clk (i_clk),
        .i_num (r_mag[1]),
        .i_den (r_mag[3]),
        .o_quo (n_qy),
        .o_ovf (n_oy)
    );

    // Side band travels alongside the dividers; the clip test enters here.
    t_side r_side [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_side[i] <= '0;
        end else begin
            r_side[0].valid <= r_v3;
            r_side[0].clip  <= (r_mag[2] >= r_mag[3]);
            r_side[0].neg_x <= r_sgn[0] != r_sgn[3];
            r_side[0].neg_y <= r_sgn[1] != r_sgn[3];
            for (int i = 1; i < DIV_LAT; i++) r_side[i] <= r_side[i-1];
        end
    end

    // Saturate against the signed range, then apply the sign.
    function automatic logic [QUO_W-1:0] finish(input logic [QUO_W-1:0] q,
                                               input logic ovf,
                                               input logic neg);
        logic [QUO_W-1:0] lim;
        logic [QUO_W-1:0] v;
        lim = neg ? NEG_LIMIT : POS_LIMIT;
        v   = (ovf || q > lim) ? lim : q;
        return neg ? QUO_W'(-v) : v;
    endfunction

    t_side n_last;
    t_out  n_res;
    assign n_last = r_side[DIV_LAT-1];

    always_comb begin
        if (n_last.clip) begin
            n_res.screen_x = CLIP_VAL;
            n_res.screen_y = CLIP_VAL;
            n_res.clipped  = 1'b1;
        end else begin
            n_res.screen_x = finish(n_qx, n_ox, n_last.neg_x);
            n_res.screen_y = finish(n_qy, n_oy, n_last.neg_y);
            n_res.clipped  = 1'b0;
        end
    end

    // Output register for the result and its valid bit.
    logic r_valid;
    t_out r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= n_last.valid;
        r_result <= n_res;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule
`default_nettype wire
